/* rtl/urb_pkg.sv */
// Shared types and constants for the UART receive/transmit ring buffers.
// No dependencies; every other file in rtl/ imports this package.
package urb_pkg;

  localparam int unsigned URB_RX_DEPTH_DEF = 256;
  localparam int unsigned URB_TX_DEPTH_DEF = 256;

  // Size registers are 9 bits wide and reset to 256 entries.
  localparam int unsigned SIZE_W     = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam int unsigned MIN_SIZE   = 2;

  // Configuration register indexes.
  localparam logic CFG_RX_SIZE = 1'b0;
  localparam logic CFG_TX_SIZE = 1'b1;

  // Request codes.
  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_LINE  = 3'd2;
  localparam logic [2:0] REQ_READY = 3'd3;
  localparam logic [2:0] REQ_START = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TX_FULL  = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        status_code;
    logic [7:0]        rx_byte;
    logic              tx_byte_valid;
    logic [7:0]        tx_byte;
    logic              tx_irq_enable;
    logic [SIZE_W-1:0] tx_free;
  } urb_result_t;

endpackage

/* rtl/uart_rx_tx_ring_buffers.sv */
// Top level of the UART receive/transmit ring buffers.
// Depends on urb_pkg, urb_ring and urb_out_buf.
//
// Usage: each input beat carries one request (host push, host pop, line byte
// received, transmit ready, start transmit) and yields exactly one result
// beat with the status, any popped byte, any byte for the line transmitter,
// the transmit interrupt enable and the transmit ring's free space.
// The size registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while no request is in flight; the block does not
// enforce this. Sizes below 2 act as 2, above the depth as the depth. Each
// accepted result is registered in the result buffer. Throughput: one request
// per cycle while in_stall is low; each ring keeps its next read byte prefetched.
// Reset: all indices go to zero, the transmitter goes idle, both sizes go to
// 256 and the result buffer empties. The ring contents are not cleared.
// Stall: results queue in a two-entry buffer; in_stall rises once the second
// entry is occupied and stays until the receiver takes a beat.
module uart_rx_tx_ring_buffers
  import urb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = URB_RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = URB_TX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [7:0]        data_byte,
  input  logic [2:0]        line_errors,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status_code,
  output logic [7:0]        rx_byte,
  output logic              tx_byte_valid,
  output logic [7:0]        tx_byte,
  output logic              tx_irq_enable,
  output logic [SIZE_W-1:0] tx_free
);

  localparam int unsigned RX_IW = $clog2(RX_DEPTH);
  localparam int unsigned RX_SW = RX_IW + 1;
  localparam int unsigned RX_CW = (RX_SW > SIZE_W) ? RX_SW : SIZE_W;
  localparam int unsigned TX_IW = $clog2(TX_DEPTH);
  localparam int unsigned TX_SW = TX_IW + 1;
  localparam int unsigned TX_CW = (TX_SW > SIZE_W) ? TX_SW : SIZE_W;
  localparam int unsigned FW    = (TX_IW + 2 > SIZE_W + 1) ? TX_IW + 2 : SIZE_W + 1;

  logic [SIZE_W-1:0] rx_size;
  logic [SIZE_W-1:0] tx_size;
  logic [RX_CW-1:0]  rx_size_ext;
  logic [TX_CW-1:0]  tx_size_ext;
  logic [RX_CW-1:0]  rx_eff_w;
  logic [TX_CW-1:0]  tx_eff_w;
  logic [RX_SW-1:0]  rx_eff;
  logic [TX_SW-1:0]  tx_eff;

  logic              accept;
  logic              buf_full;
  logic              tx_active;
  logic              tx_active_next;

  logic              rx_wr_en;
  logic              rx_rd_en;
  logic [7:0]        rx_rd_data;
  logic [RX_IW-1:0]  rx_wr_idx;
  logic [RX_IW-1:0]  rx_rd_idx;

  logic              tx_wr_en;
  logic              tx_rd_en;
  logic [7:0]        tx_rd_data;
  logic [TX_IW-1:0]  tx_wr_idx;
  logic [TX_IW-1:0]  tx_rd_idx;
  logic [TX_IW-1:0]  tx_wr_idx_next;
  logic [TX_IW-1:0]  tx_rd_idx_next;

  logic              rx_nonempty;
  logic              tx_nonempty;
  logic              tx_full;
  logic signed [FW-1:0] fill_diff;
  logic signed [FW-1:0] free_diff;
  logic signed [FW-1:0] tsz_s;

  urb_result_t       result;
  urb_result_t       out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_size <= SIZE_RESET;
      tx_size <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RX_SIZE: rx_size <= cfg_data;
        CFG_TX_SIZE: tx_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the ring sizes into [2, depth].
  always_comb begin
    rx_size_ext = RX_CW'(rx_size);
    tx_size_ext = TX_CW'(tx_size);
    if (rx_size_ext < RX_CW'(MIN_SIZE)) begin
      rx_eff_w = RX_CW'(MIN_SIZE);
    end else if (rx_size_ext > RX_CW'(RX_DEPTH)) begin
      rx_eff_w = RX_CW'(RX_DEPTH);
    end else begin
      rx_eff_w = rx_size_ext;
    end
    if (tx_size_ext < TX_CW'(MIN_SIZE)) begin
      tx_eff_w = TX_CW'(MIN_SIZE);
    end else if (tx_size_ext > TX_CW'(TX_DEPTH)) begin
      tx_eff_w = TX_CW'(TX_DEPTH);
    end else begin
      tx_eff_w = tx_size_ext;
    end
  end

  assign rx_eff = rx_eff_w[RX_SW-1:0];
  assign tx_eff = tx_eff_w[TX_SW-1:0];

  assign in_stall    = buf_full;
  assign accept      = in_valid && !buf_full;
  assign rx_nonempty = (rx_rd_idx != rx_wr_idx);
  assign tx_nonempty = (tx_rd_idx != tx_wr_idx);
  assign tsz_s       = $signed(FW'(tx_eff));

  // The transmit ring counts as full when it holds size-1 bytes.
  always_comb begin
    fill_diff = $signed(FW'(tx_wr_idx)) - $signed(FW'(tx_rd_idx));
    if (fill_diff < 0) begin
      fill_diff = fill_diff + tsz_s;
    end
    tx_full = (fill_diff >= tsz_s - FW'(1));
  end

  always_comb begin
    rx_wr_en       = 1'b0;
    rx_rd_en       = 1'b0;
    tx_wr_en       = 1'b0;
    tx_rd_en       = 1'b0;
    tx_active_next = tx_active;
    result.status_code   = ST_OK;
    result.rx_byte       = 8'd0;
    result.tx_byte_valid = 1'b0;
    result.tx_byte       = 8'd0;
    case (req_type)
      REQ_PUSH: begin
        if (tx_full) begin
          result.status_code = ST_TX_FULL;
        end else begin
          tx_wr_en = accept;
        end
      end
      REQ_POP: begin
        if (rx_nonempty) begin
          rx_rd_en       = accept;
          result.rx_byte = rx_rd_data;
        end else begin
          result.status_code = ST_RX_EMPTY;
        end
      end
      REQ_LINE: begin
        rx_wr_en = accept && (line_errors == 3'd0);
      end
      REQ_READY: begin
        if (tx_nonempty) begin
          tx_rd_en             = accept;
          result.tx_byte_valid = 1'b1;
          result.tx_byte       = tx_rd_data;
        end else begin
          tx_active_next = 1'b0;
        end
      end
      REQ_START: begin
        if (!tx_active && tx_nonempty) begin
          tx_rd_en             = accept;
          result.tx_byte_valid = 1'b1;
          result.tx_byte       = tx_rd_data;
          tx_active_next       = 1'b1;
        end
      end
      default: ;
    endcase
    result.tx_irq_enable = tx_active_next;
  end

  // Free space after the step: read minus write, plus size when not positive.
  always_comb begin
    free_diff = $signed(FW'(tx_rd_idx_next)) - $signed(FW'(tx_wr_idx_next));
    if (free_diff <= 0) begin
      free_diff = free_diff + tsz_s;
    end
    result.tx_free = free_diff[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_active <= 1'b0;
    end else if (accept) begin
      tx_active <= tx_active_next;
    end
  end

  urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk         (clk),
    .rst         (rst),
    .size        (rx_eff),
    .wr_en       (rx_wr_en),
    .wr_data     (data_byte),
    .rd_en       (rx_rd_en),
    .rd_data     (rx_rd_data),
    .wr_idx      (rx_wr_idx),
    .rd_idx      (rx_rd_idx),
    .wr_idx_next (),
    .rd_idx_next ()
  );

  urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk         (clk),
    .rst         (rst),
    .size        (tx_eff),
    .wr_en       (tx_wr_en),
    .wr_data     (data_byte),
    .rd_en       (tx_rd_en),
    .rd_data     (tx_rd_data),
    .wr_idx      (tx_wr_idx),
    .rd_idx      (tx_rd_idx),
    .wr_idx_next (tx_wr_idx_next),
    .rd_idx_next (tx_rd_idx_next)
  );

  urb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status_code   = out_data.status_code;
  assign rx_byte       = out_data.rx_byte;
  assign tx_byte_valid = out_data.tx_byte_valid;
  assign tx_byte       = out_data.tx_byte;
  assign tx_irq_enable = out_data.tx_irq_enable;
  assign tx_free       = out_data.tx_free;

endmodule

/* rtl/urb_ring.sv */
// One byte ring: storage array, write and read indices, and a prefetched read word.
// Depends on urb_pkg.
module urb_ring
  import urb_pkg::*;
#(
  parameter int unsigned DEPTH = URB_RX_DEPTH_DEF,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned SW = IW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [SW-1:0] size,
  input  logic          wr_en,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  output logic [7:0]    rd_data,
  output logic [IW-1:0] wr_idx,
  output logic [IW-1:0] rd_idx,
  output logic [IW-1:0] wr_idx_next,
  output logic [IW-1:0] rd_idx_next
);

  logic [7:0]    mem [DEPTH];
  logic [SW-1:0] wr_inc;
  logic [SW-1:0] rd_inc;
  logic [IW-1:0] wr_adv;
  logic [IW-1:0] rd_adv;

  // An index wraps to zero once the advanced value reaches the ring size.
  always_comb begin
    wr_inc = SW'(wr_idx) + SW'(1);
    rd_inc = SW'(rd_idx) + SW'(1);
    wr_adv = (wr_inc >= size) ? '0 : wr_inc[IW-1:0];
    rd_adv = (rd_inc >= size) ? '0 : rd_inc[IW-1:0];
    if (rst) begin
      wr_idx_next = '0;
      rd_idx_next = '0;
    end else begin
      wr_idx_next = wr_en ? wr_adv : wr_idx;
      rd_idx_next = rd_en ? rd_adv : rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx <= wr_idx_next;
    rd_idx <= rd_idx_next;
  end

  // rd_data always holds the entry at rd_idx. A write to the entry about to
  // be read is forwarded, since the array read returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (wr_en && wr_idx == rd_idx_next) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_idx_next];
    end
  end

endmodule

/* rtl/urb_out_buf.sv */
// Two-entry result buffer between the ring logic and the result channel.
// Depends on urb_pkg for the result type.
module urb_out_buf
  import urb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  urb_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output urb_result_t out_data
);

  urb_result_t head;
  urb_result_t tail;
  logic        head_valid;
  logic        tail_valid;
  logic        pop;

  assign pop       = head_valid && !out_stall;
  assign out_valid = head_valid;
  assign out_data  = head;
  assign full      = tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop && push) begin
      head <= push_data;
    end else if (pop) begin
      head       <= tail;
      head_valid <= tail_valid;
      tail_valid <= 1'b0;
    end else if (push) begin
      if (!head_valid) begin
        head       <= push_data;
        head_valid <= 1'b1;
      end else begin
        tail       <= push_data;
        tail_valid <= 1'b1;
      end
    end
  end

endmodule
